[hw/rtl/ssd_pkg.sv]
// ----------------------------------------------------------------------------
// ssd_pkg
// Widths, types and codes shared by the segment distance pipeline.
// ----------------------------------------------------------------------------
package ssd_pkg;

  // Coordinate width of one input field (signed Q12.12 by default).
  localparam int COORD_W = 24;
  // Difference vectors u, v, w.
  localparam int DW = COORD_W + 1;
  // One product of two difference components.
  localparam int PW = 2 * DW;
  // Dot products a..e and the derived -d and b-d.
  localparam int DOTW = PW + 2;
  // Determinant and s/t numerators, signed.
  localparam int NW = 2 * DOTW + 1;
  // The same values once they are known to be non-negative.
  localparam int UW = NW - 1;
  // Fraction bits of s and t; the quotient also holds the value one.
  localparam int FRAC = 32;
  localparam int QW = FRAC + 1;
  // Distance vector component in units of 2^-44.
  localparam int CW = DW + FRAC + 3;
  // Operand width of the signed multipliers, split into two halves.
  localparam int MW0 = (DOTW > CW) ? DOTW : CW;
  localparam int MW = ((MW0 + 1) / 2) * 2;
  localparam int HW = MW / 2;
  localparam int SQW = 2 * MW;
  localparam int MUL_LAT = 5;
  localparam int DIV_LAT = QW;

  // Output format and saturation.
  localparam int OUT_W = 52;
  localparam int OUT_SHIFT = 2 * FRAC;
  localparam int SUMW = (SQW + 2 > OUT_SHIFT + OUT_W + 1) ? SQW + 2 : OUT_SHIFT + OUT_W + 1;
  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  // Register width and the scale of the determinant threshold.
  localparam int LIM_W = 8;
  localparam int DET_LIM_SHIFT = 24;
  localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(1);

  typedef logic signed [DW-1:0] diff_t;

  typedef struct packed {
    diff_t [2:0] u;
    diff_t [2:0] v;
    diff_t [2:0] w;
  } geo_t;

  typedef struct packed {
    logic signed [DOTW-1:0] a;
    logic signed [DOTW-1:0] b;
    logic signed [DOTW-1:0] c;
    logic signed [DOTW-1:0] d;
    logic signed [DOTW-1:0] e;
    logic signed [DOTW-1:0] nd;
    logic signed [DOTW-1:0] ndb;
  } dots_t;

  // Which segments are too short to solve the general case.
  typedef enum logic [1:0] {
    MODE_GEN,
    MODE_DEG_A,
    MODE_DEG_C,
    MODE_BOTH
  } mode_t;

  typedef struct packed {
    logic signed [NW-1:0] sn;
    logic signed [NW-1:0] sd;
    logic signed [NW-1:0] tn;
    logic signed [NW-1:0] td;
    logic signed [NW-1:0] nd;
    logic signed [NW-1:0] ndb;
    logic signed [NW-1:0] a;
    mode_t mode;
  } sel_t;

endpackage

[hw/rtl/ssd_if.sv]
// ----------------------------------------------------------------------------
// ssd_if
// Valid/ready channels of the segment distance block.
// ----------------------------------------------------------------------------
interface ssd_query_if;
  import ssd_pkg::*;
  logic valid;
  logic ready;
  logic signed [COORD_W-1:0] first_start_x;
  logic signed [COORD_W-1:0] first_start_y;
  logic signed [COORD_W-1:0] first_start_z;
  logic signed [COORD_W-1:0] first_end_x;
  logic signed [COORD_W-1:0] first_end_y;
  logic signed [COORD_W-1:0] first_end_z;
  logic signed [COORD_W-1:0] second_start_x;
  logic signed [COORD_W-1:0] second_start_y;
  logic signed [COORD_W-1:0] second_start_z;
  logic signed [COORD_W-1:0] second_end_x;
  logic signed [COORD_W-1:0] second_end_y;
  logic signed [COORD_W-1:0] second_end_z;

  modport source (
    output valid, first_start_x, first_start_y, first_start_z,
    output first_end_x, first_end_y, first_end_z,
    output second_start_x, second_start_y, second_start_z,
    output second_end_x, second_end_y, second_end_z,
    input ready
  );
  modport sink (
    input valid, first_start_x, first_start_y, first_start_z,
    input first_end_x, first_end_y, first_end_z,
    input second_start_x, second_start_y, second_start_z,
    input second_end_x, second_end_y, second_end_z,
    output ready
  );
endinterface

interface ssd_result_if;
  import ssd_pkg::*;
  logic valid;
  logic ready;
  logic [OUT_W-1:0] distance_squared;

  modport source (output valid, distance_squared, input ready);
  modport sink (input valid, distance_squared, output ready);
endinterface

interface ssd_cfg_if;
  import ssd_pkg::*;
  logic valid;
  logic ready;
  logic [LIM_W-1:0] near_zero_limit;

  modport source (output valid, near_zero_limit, input ready);
  modport sink (input valid, near_zero_limit, output ready);
endinterface

[hw/rtl/ssd_smul.sv]
// ----------------------------------------------------------------------------
// ssd_smul
// Pipelined signed multiplier built from four half-width partial products.
// ----------------------------------------------------------------------------
module ssd_smul (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [ssd_pkg::MW-1:0]  a,
  input  logic signed [ssd_pkg::MW-1:0]  b,
  output logic signed [ssd_pkg::SQW-1:0] p
);
  import ssd_pkg::*;

  logic           neg1, neg2, neg3, neg4;
  logic [MW-1:0]  ma, mb;
  logic [MW-1:0]  p0, p1, p2, p3;
  logic [SQW-1:0] lohi;
  logic [MW:0]    mid;
  logic [SQW-1:0] mag;

  // Sign and magnitude of both operands.
  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= a[MW-1] ^ b[MW-1];
      ma   <= a[MW-1] ? MW'(-a) : MW'(a);
      mb   <= b[MW-1] ? MW'(-b) : MW'(b);
    end
  end

  // Four half-width partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      neg2 <= neg1;
      p0   <= ma[HW-1:0]  * mb[HW-1:0];
      p1   <= ma[MW-1:HW] * mb[HW-1:0];
      p2   <= ma[HW-1:0]  * mb[MW-1:HW];
      p3   <= ma[MW-1:HW] * mb[MW-1:HW];
    end
  end

  // The outer products sit side by side; the cross terms are added first.
  always_ff @(posedge clk) begin
    if (en) begin
      neg3 <= neg2;
      lohi <= {p3, p0};
      mid  <= (MW + 1)'(p1) + (MW + 1)'(p2);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg4 <= neg3;
      mag  <= lohi + (SQW'(mid) << HW);
    end
  end

  // Restore the sign.
  always_ff @(posedge clk) begin
    if (en) begin
      p <= neg4 ? $signed(-mag) : $signed(mag);
    end
  end

endmodule

[hw/rtl/ssd_div.sv]
// ----------------------------------------------------------------------------
// ssd_div
// Pipelined restoring divider: floor(num * 2^FRAC / den) for 0 <= num <= den.
// ----------------------------------------------------------------------------
module ssd_div (
  input  logic                     clk,
  input  logic                     en,
  input  logic [ssd_pkg::UW-1:0]   num,
  input  logic [ssd_pkg::UW-1:0]   den,
  output logic [ssd_pkg::QW-1:0]   quo
);
  import ssd_pkg::*;

  logic [UW-1:0] rem_q [QW];
  logic [UW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];

  // One quotient bit per stage, most significant first.
  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [UW:0]   trial;
    logic [UW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic          ge;

    if (k == 0) begin : g_first
      assign trial  = {1'b0, num};
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign trial  = {rem_q[k-1], 1'b0};
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign ge = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= ge ? UW'(trial - {1'b0, den_in}) : UW'(trial);
        den_q[k] <= den_in;
        quo_q[k] <= {quo_in[QW-2:0], ge};
      end
    end
  end

  assign quo = quo_q[QW-1];

endmodule

[hw/rtl/segment_segment_distance_squared.sv]
// ----------------------------------------------------------------------------
// segment_segment_distance_squared
// Squared closest distance between two 3D segments, fully pipelined.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake     Carries
//  query    in         valid/ready   twelve endpoint coordinates, Q12.12
//  result   out        valid/ready   distance_squared, Q28.24, saturating
//  cfg      in         valid/ready   near_zero_limit register
//
//  One request enters per cycle while the output is not stalled. Most of
//  the pipeline lies in the 33-stage divider for s and t and in the two
//  five-stage multiplier chains (determinant terms and squared components).
//  Reset clears the valid bits of every stage and loads near_zero_limit = 1.
//  When the output register holds an unread result, the whole pipeline
//  stalls together; nothing moves, so nothing is lost or repeated.
//
module segment_segment_distance_squared (
  input  logic       clk,
  input  logic       rst,
  ssd_query_if.sink  query,
  ssd_result_if.source result,
  ssd_cfg_if.sink    cfg
);
  import ssd_pkg::*;

  localparam int S_DOT   = 3;
  localparam int S_MUL   = S_DOT + MUL_LAT;
  localparam int S_DET   = S_MUL + 1;
  localparam int S_SEL   = S_DET + 1;
  localparam int S_CLAMP = S_SEL + 1;
  localparam int S_DIV   = S_CLAMP + DIV_LAT;
  localparam int S_PROD  = S_DIV + 1;
  localparam int S_COMP  = S_PROD + 1;
  localparam int S_SQ    = S_COMP + MUL_LAT;
  localparam int S_SUM   = S_SQ + 1;
  localparam int S_OUT   = S_SUM + 1;

  logic             en;
  logic [S_OUT:0]   vld;
  logic [LIM_W-1:0] lim;

  // Configuration register; the user must write it only while idle, the block does not enforce this.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      lim <= LIM_RESET;
    end else if (cfg.valid) begin
      lim <= cfg.near_zero_limit;
    end
  end

  // Global advance and valid bits per stage.
  assign en          = !result.valid || result.ready;
  assign query.ready = en;
  assign result.valid = vld[S_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[S_OUT-1:0], query.valid};
    end
  end

  // Input register.
  logic signed [COORD_W-1:0] pt [12];
  always_ff @(posedge clk) begin
    if (en) begin
      pt[0]  <= query.first_start_x;
      pt[1]  <= query.first_start_y;
      pt[2]  <= query.first_start_z;
      pt[3]  <= query.first_end_x;
      pt[4]  <= query.first_end_y;
      pt[5]  <= query.first_end_z;
      pt[6]  <= query.second_start_x;
      pt[7]  <= query.second_start_y;
      pt[8]  <= query.second_start_z;
      pt[9]  <= query.second_end_x;
      pt[10] <= query.second_end_y;
      pt[11] <= query.second_end_z;
    end
  end

  // Direction vectors and start offset, carried down to the final stages.
  geo_t geo_q [1:S_PROD];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        geo_q[1].u[i] <= DW'(pt[3+i]) - DW'(pt[i]);
        geo_q[1].v[i] <= DW'(pt[9+i]) - DW'(pt[6+i]);
        geo_q[1].w[i] <= DW'(pt[i]) - DW'(pt[6+i]);
      end
      for (int k = 2; k <= S_PROD; k++) begin
        geo_q[k] <= geo_q[k-1];
      end
    end
  end

  // Component products of the five dot products.
  logic signed [PW-1:0] uu [3], uv [3], vv [3], uw [3], vw [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        uu[i] <= $signed(geo_q[1].u[i]) * $signed(geo_q[1].u[i]);
        uv[i] <= $signed(geo_q[1].u[i]) * $signed(geo_q[1].v[i]);
        vv[i] <= $signed(geo_q[1].v[i]) * $signed(geo_q[1].v[i]);
        uw[i] <= $signed(geo_q[1].u[i]) * $signed(geo_q[1].w[i]);
        vw[i] <= $signed(geo_q[1].v[i]) * $signed(geo_q[1].w[i]);
      end
    end
  end

  // Dot products a..e.
  logic signed [DOTW-1:0] a3, b3, c3, d3, e3;
  always_ff @(posedge clk) begin
    if (en) begin
      a3 <= DOTW'(uu[0]) + DOTW'(uu[1]) + DOTW'(uu[2]);
      b3 <= DOTW'(uv[0]) + DOTW'(uv[1]) + DOTW'(uv[2]);
      c3 <= DOTW'(vv[0]) + DOTW'(vv[1]) + DOTW'(vv[2]);
      d3 <= DOTW'(uw[0]) + DOTW'(uw[1]) + DOTW'(uw[2]);
      e3 <= DOTW'(vw[0]) + DOTW'(vw[1]) + DOTW'(vw[2]);
    end
  end

  // Degenerate segment check and the dot products held beside the multipliers.
  logic signed [LIM_W:0] lim_s;
  logic                  deg_a, deg_c;
  dots_t                 dl_q   [S_DOT+1:S_MUL];
  mode_t                 mode_q [S_DOT+1:S_MUL];

  assign lim_s = $signed({1'b0, lim});
  assign deg_a = (a3 == '0) || (a3 < lim_s);
  assign deg_c = (c3 == '0) || (c3 < lim_s);

  always_ff @(posedge clk) begin
    if (en) begin
      dl_q[S_DOT+1].a   <= a3;
      dl_q[S_DOT+1].b   <= b3;
      dl_q[S_DOT+1].c   <= c3;
      dl_q[S_DOT+1].d   <= d3;
      dl_q[S_DOT+1].e   <= e3;
      dl_q[S_DOT+1].nd  <= -d3;
      dl_q[S_DOT+1].ndb <= b3 - d3;
      if (deg_a && deg_c) begin
        mode_q[S_DOT+1] <= MODE_BOTH;
      end else if (deg_a) begin
        mode_q[S_DOT+1] <= MODE_DEG_A;
      end else if (deg_c) begin
        mode_q[S_DOT+1] <= MODE_DEG_C;
      end else begin
        mode_q[S_DOT+1] <= MODE_GEN;
      end
      for (int k = S_DOT + 2; k <= S_MUL; k++) begin
        dl_q[k]   <= dl_q[k-1];
        mode_q[k] <= mode_q[k-1];
      end
    end
  end

  // Products for the determinant and the s and t numerators.
  logic signed [SQW-1:0] m_ac, m_bb, m_be, m_cd, m_ae, m_bd;

  ssd_smul u_mul_ac (.clk, .en, .a(MW'(a3)), .b(MW'(c3)), .p(m_ac));
  ssd_smul u_mul_bb (.clk, .en, .a(MW'(b3)), .b(MW'(b3)), .p(m_bb));
  ssd_smul u_mul_be (.clk, .en, .a(MW'(b3)), .b(MW'(e3)), .p(m_be));
  ssd_smul u_mul_cd (.clk, .en, .a(MW'(c3)), .b(MW'(d3)), .p(m_cd));
  ssd_smul u_mul_ae (.clk, .en, .a(MW'(a3)), .b(MW'(e3)), .p(m_ae));
  ssd_smul u_mul_bd (.clk, .en, .a(MW'(b3)), .b(MW'(d3)), .p(m_bd));

  // Determinant and unclamped numerators.
  logic signed [NW-1:0] det9, sn9, tn9;
  dots_t                dots9;
  mode_t                mode9;
  always_ff @(posedge clk) begin
    if (en) begin
      det9  <= NW'(m_ac) - NW'(m_bb);
      sn9   <= NW'(m_be) - NW'(m_cd);
      tn9   <= NW'(m_ae) - NW'(m_bd);
      dots9 <= dl_q[S_MUL];
      mode9 <= mode_q[S_MUL];
    end
  end

  // Parallel check, numerator selection per mode and first clamp of s.
  logic signed [NW-1:0] lim_det;
  logic                 det_nz;
  sel_t                 sel_next, sel_q;

  assign lim_det = $signed({{(NW - LIM_W - DET_LIM_SHIFT){1'b0}}, lim,
                            {DET_LIM_SHIFT{1'b0}}});
  assign det_nz  = (det9 == '0) || (det9 < lim_det);

  always_comb begin
    sel_next.nd   = NW'(dots9.nd);
    sel_next.ndb  = NW'(dots9.ndb);
    sel_next.a    = NW'(dots9.a);
    sel_next.mode = mode9;
    sel_next.sn   = '0;
    sel_next.sd   = NW'(1);
    sel_next.tn   = '0;
    sel_next.td   = NW'(1);
    case (mode9)
      MODE_BOTH: begin
        sel_next.sn = '0;
      end
      MODE_DEG_A: begin
        sel_next.tn = NW'(dots9.e);
        sel_next.td = NW'(dots9.c);
      end
      MODE_DEG_C: begin
        sel_next.sn = NW'(dots9.nd);
        sel_next.sd = NW'(dots9.a);
      end
      default: begin
        if (det_nz) begin
          sel_next.tn = NW'(dots9.e);
          sel_next.td = NW'(dots9.c);
        end else if (sn9 < 0) begin
          sel_next.sd = det9;
          sel_next.tn = NW'(dots9.e);
          sel_next.td = NW'(dots9.c);
        end else if (sn9 > det9) begin
          sel_next.sn = det9;
          sel_next.sd = det9;
          sel_next.tn = NW'(dots9.e) + NW'(dots9.b);
          sel_next.td = NW'(dots9.c);
        end else begin
          sel_next.sn = sn9;
          sel_next.sd = det9;
          sel_next.tn = tn9;
          sel_next.td = det9;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sel_q <= sel_next;
    end
  end

  // Clamp of t, which may move s to an end of the first segment, and clamp of s for a point-like second segment.
  logic signed [NW-1:0] sn_c, sd_c, tn_c, td_c;
  logic [UW-1:0]        sn_q, sd_q, tn_q, td_q;

  always_comb begin
    sn_c = sel_q.sn;
    sd_c = sel_q.sd;
    tn_c = sel_q.tn;
    td_c = sel_q.td;
    case (sel_q.mode)
      MODE_DEG_A: begin
        if (sel_q.tn < 0) begin
          tn_c = '0;
        end else if (sel_q.tn > sel_q.td) begin
          tn_c = sel_q.td;
        end
      end
      MODE_DEG_C: begin
        if (sel_q.sn < 0) begin
          sn_c = '0;
        end else if (sel_q.sn > sel_q.sd) begin
          sn_c = sel_q.sd;
        end
      end
      MODE_GEN: begin
        if (sel_q.tn < 0) begin
          tn_c = '0;
          if (sel_q.nd < 0) begin
            sn_c = '0;
          end else if (sel_q.nd > sel_q.a) begin
            sn_c = sel_q.sd;
          end else begin
            sn_c = sel_q.nd;
            sd_c = sel_q.a;
          end
        end else if (sel_q.tn > sel_q.td) begin
          tn_c = sel_q.td;
          if (sel_q.ndb < 0) begin
            sn_c = '0;
          end else if (sel_q.ndb > sel_q.a) begin
            sn_c = sel_q.sd;
          end else begin
            sn_c = sel_q.ndb;
            sd_c = sel_q.a;
          end
        end
      end
      default: begin
        sn_c = sel_q.sn;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sn_q <= sn_c[UW-1:0];
      sd_q <= sd_c[UW-1:0];
      tn_q <= tn_c[UW-1:0];
      td_q <= td_c[UW-1:0];
    end
  end

  // Closest parameters s and t in Q1.32.
  logic [QW-1:0] sc, tc;
  ssd_div u_div_s (.clk, .en, .num(sn_q), .den(sd_q), .quo(sc));
  ssd_div u_div_t (.clk, .en, .num(tn_q), .den(td_q), .quo(tc));

  // Scaled direction vectors.
  logic signed [CW-1:0] sp [3], tp [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sp[i] <= $signed({1'b0, sc}) * $signed(geo_q[S_DIV].u[i]);
        tp[i] <= $signed({1'b0, tc}) * $signed(geo_q[S_DIV].v[i]);
      end
    end
  end

  // Distance vector in units of 2^-44.
  logic signed [CW-1:0] comp [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        comp[i] <= (CW'($signed(geo_q[S_PROD].w[i])) <<< FRAC) + sp[i] - tp[i];
      end
    end
  end

  // Squared components.
  logic signed [SQW-1:0] sq [3];
  for (genvar i = 0; i < 3; i++) begin : g_sq
    ssd_smul u_mul_sq (.clk, .en, .a(MW'(comp[i])), .b(MW'(comp[i])), .p(sq[i]));
  end

  // Sum with rounding half up.
  logic [SUMW-1:0] s01, s2h, tot;
  always_ff @(posedge clk) begin
    if (en) begin
      s01 <= SUMW'($unsigned(sq[0])) + SUMW'($unsigned(sq[1]));
      s2h <= SUMW'($unsigned(sq[2])) + (SUMW'(1) << (OUT_SHIFT - 1));
    end
  end

  // Scale to Q28.24 and saturate.
  logic sat;
  assign tot = s01 + s2h;
  assign sat = |tot[SUMW-1:OUT_SHIFT+OUT_W];

  always_ff @(posedge clk) begin
    if (en) begin
      result.distance_squared <= sat ? OUT_MAX : tot[OUT_SHIFT+OUT_W-1:OUT_SHIFT];
    end
  end

  // The divider only ever sees a proper fraction with a positive divisor.
  a_div_s: assert property (@(posedge clk) disable iff (rst)
    vld[S_CLAMP] |-> (sn_q <= sd_q) && (sd_q != '0))
    else $error("s numerator outside [0, denominator]");

  a_div_t: assert property (@(posedge clk) disable iff (rst)
    vld[S_CLAMP] |-> (tn_q <= td_q) && (td_q != '0))
    else $error("t numerator outside [0, denominator]");

  // A stall freezes every stage.
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline moved during a stall");

  // An overflowing sum leaves as the maximum code.
  a_sat: assert property (@(posedge clk) disable iff (rst)
    en && vld[S_SUM] && sat |=> result.distance_squared == OUT_MAX)
    else $error("saturation lost");

endmodule

[verif/ssd_tb_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_tb_if
// Note: the block's channel interfaces live in the RTL file list; this file
// only holds a small record type shared by the testbench top.
// ----------------------------------------------------------------------------
package ssd_tb_pkg;
  import ssd_pkg::*;

  // One distance request: twelve coordinates in the order of the query port.
  typedef struct {
    logic signed [COORD_W-1:0] crd [12];
  } seg_request_t;
endpackage

[verif/tb_segment_segment_distance_squared.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_segment_distance_squared
// Drives random and directed segment pairs with random gaps and stalls,
// predicts each squared distance in exact integer arithmetic (or takes a typed-in one) and compares.
// ----------------------------------------------------------------------------
module tb_segment_segment_distance_squared;
  import ssd_pkg::*;
  import ssd_tb_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 80;
  localparam int NUM_RANDOM = 1500;
  localparam int NUM_DIRECTED = 14;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int cycle_count = 0;
  int errors = 0;
  bit stim_done = 1'b0;
  logic [LIM_W-1:0] limit_now = LIM_RESET;
  logic [OUT_W-1:0] pending_dist [$];

  ssd_query_if  query ();
  ssd_result_if result ();
  ssd_cfg_if    cfg ();

  segment_segment_distance_squared dut (
    .clk(clk), .rst(rst), .query(query), .result(result), .cfg(cfg)
  );

  // Clock with a 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Floor of n * 2^32 / den, or zero when n < 0 or den <= 0.
  function automatic logic [FRAC:0] frac_quot(logic signed [255:0] n,
                                              logic signed [255:0] den);
    if (n < 0 || den <= 0) return '0;
    return (FRAC + 1)'((n <<< FRAC) / den);
  endfunction

  // Exact squared closest distance, rounded and saturated to Q28.24.
  function automatic logic [OUT_W-1:0] closest_dist_sq(seg_request_t r,
                                                       logic [LIM_W-1:0] lim8);
    logic signed [255:0] p [12];
    logic signed [255:0] u [3], v [3], w [3];
    logic signed [255:0] a, b, c, d, e, sn, sd, tn, td, nd, ndb, det, lim, lim_det;
    logic signed [255:0] comp, sum, sc, tc;
    bit deg_a, deg_c;
    for (int i = 0; i < 12; i++) p[i] = 256'(r.crd[i]);
    for (int i = 0; i < 3; i++) begin
      u[i] = p[3+i] - p[i];
      v[i] = p[9+i] - p[6+i];
      w[i] = p[i] - p[6+i];
    end
    a = u[0]*u[0] + u[1]*u[1] + u[2]*u[2];
    b = u[0]*v[0] + u[1]*v[1] + u[2]*v[2];
    c = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
    d = u[0]*w[0] + u[1]*w[1] + u[2]*w[2];
    e = v[0]*w[0] + v[1]*w[1] + v[2]*w[2];
    lim = 256'(lim8);
    lim_det = lim <<< DET_LIM_SHIFT;
    deg_a = (a == 0) || (a < lim);
    deg_c = (c == 0) || (c < lim);
    sn = 0; sd = 1; tn = 0; td = 1;
    if (deg_a || deg_c) begin
      if (deg_a && !deg_c) begin
        tn = e; td = c;
        if (tn < 0) tn = 0;
        else if (tn > td) tn = td;
      end else if (deg_c && !deg_a) begin
        sn = -d; sd = a;
        if (sn < 0) sn = 0;
        else if (sn > sd) sn = sd;
      end
    end else begin
      det = a*c - b*b;
      nd = -d;
      ndb = nd + b;
      if (det == 0 || det < lim_det) begin
        sn = 0; sd = 1; tn = e; td = c;
      end else begin
        sd = det; td = det;
        sn = b*e - c*d;
        tn = a*e - b*d;
        if (sn < 0) begin
          sn = 0; tn = e; td = c;
        end else if (sn > sd) begin
          sn = sd; tn = e + b; td = c;
        end
      end
      // Clamping t may move s to an end of the first segment.
      if (tn < 0) begin
        tn = 0;
        if (nd < 0) sn = 0;
        else if (nd > a) sn = sd;
        else begin
          sn = nd; sd = a;
        end
      end else if (tn > td) begin
        tn = td;
        if (ndb < 0) sn = 0;
        else if (ndb > a) sn = sd;
        else begin
          sn = ndb; sd = a;
        end
      end
    end
    sc = 256'(frac_quot(sn, sd));
    tc = 256'(frac_quot(tn, td));
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      comp = (w[i] <<< FRAC) + sc*u[i] - tc*v[i];
      sum = sum + comp*comp;
    end
    sum = (sum + (256'sd1 <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    if (sum > OUT_MAX) return OUT_MAX;
    return sum[OUT_W-1:0];
  endfunction

  // Write the threshold register; only called with nothing in flight.
  task automatic write_limit(logic [LIM_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.near_zero_limit <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    limit_now = val;
  endtask

  // Send one request, predicting its distance (or taking a known one).
  // Valid stays high between back-to-back requests.
  task automatic send_request(seg_request_t r, bit known, logic [OUT_W-1:0] known_val);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      query.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    query.valid <= 1'b1;
    query.first_start_x <= r.crd[0];
    query.first_start_y <= r.crd[1];
    query.first_start_z <= r.crd[2];
    query.first_end_x <= r.crd[3];
    query.first_end_y <= r.crd[4];
    query.first_end_z <= r.crd[5];
    query.second_start_x <= r.crd[6];
    query.second_start_y <= r.crd[7];
    query.second_start_z <= r.crd[8];
    query.second_end_x <= r.crd[9];
    query.second_end_y <= r.crd[10];
    query.second_end_z <= r.crd[11];
    do @(posedge clk); while (!query.ready);
    pending_dist.push_back(known ? known_val : closest_dist_sq(r, limit_now));
  endtask

  task automatic wait_drained();
    query.valid <= 1'b0;
    while (pending_dist.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random coordinate: mostly modest, sometimes full range or an extreme.
  function automatic logic signed [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(COORD_W-1){1'b0}}};
      1: return {1'b0, {(COORD_W-1){1'b1}}};
      2, 3: return COORD_W'($urandom());
      default: return COORD_W'($signed($urandom_range(0, 65535)) - 32768);
    endcase
  endfunction

  // Random pair shaped toward the interesting cases.
  function automatic seg_request_t pick_request();
    seg_request_t r;
    int kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 12; i++) r.crd[i] = pick_coord();
    case (kind)
      // Point-like first or second segment.
      0: for (int i = 0; i < 3; i++) r.crd[3+i] = r.crd[i] + $signed(2'($urandom()));
      1: for (int i = 0; i < 3; i++) r.crd[9+i] = r.crd[6+i] + $signed(2'($urandom()));
      // Parallel segments.
      2: for (int i = 0; i < 3; i++) r.crd[9+i] = r.crd[6+i] + (r.crd[3+i] - r.crd[i]);
      default: ;
    endcase
    return r;
  endfunction

  // Result side: random stalls, compare against the oldest expectation.
  initial begin
    logic [OUT_W-1:0] want;
    int stall;
    result.ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        result.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result.ready <= 1'b1;
      do @(posedge clk); while (!result.valid);
      if (pending_dist.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result.distance_squared);
        errors++;
      end else begin
        want = pending_dist.pop_front();
        if (result.distance_squared !== want) begin
          $display("%0t: distance_squared expected %h actual %h",
                   $time, want, result.distance_squared);
          errors++;
        end
      end
    end
  end

  // Directed rows: coordinates, and a typed-in distance where it is obvious.
  logic signed [COORD_W-1:0] dir_crd [NUM_DIRECTED][12];
  bit dir_known [NUM_DIRECTED];
  logic [OUT_W-1:0] dir_val [NUM_DIRECTED];

  initial begin
    seg_request_t r;
    logic signed [COORD_W-1:0] mx, mn;
    logic [LIM_W-1:0] limits [4];
    mx = {1'b0, {(COORD_W-1){1'b1}}};
    mn = {1'b1, {(COORD_W-1){1'b0}}};
    limits = '{8'd0, 8'd255, 8'd1, 8'd37};
    for (int k = 0; k < NUM_DIRECTED; k++) begin
      dir_known[k] = 1'b0;
      dir_val[k] = '0;
      for (int i = 0; i < 12; i++) dir_crd[k][i] = '0;
    end
    // All points at the origin: distance zero.
    dir_known[0] = 1'b1;
    // Both points, one unit apart in x: distance one.
    dir_crd[1][6] = 24'sd4096; dir_crd[1][9] = 24'sd4096;
    dir_known[1] = 1'b1; dir_val[1] = 52'd1 << 24;
    // Far corners give the largest distance, 3 * (2^24 - 1)^2.
    for (int i = 0; i < 6; i++) begin
      dir_crd[2][i] = mn; dir_crd[2][6+i] = mx;
    end
    dir_known[2] = 1'b1; dir_val[2] = 52'd844424829468675;
    // Crossing segments in x and y at z distance 1.
    dir_crd[3][0] = -24'sd4096; dir_crd[3][3] = 24'sd4096;
    dir_crd[3][7] = -24'sd4096; dir_crd[3][10] = 24'sd4096;
    dir_crd[3][8] = 24'sd4096; dir_crd[3][11] = 24'sd4096;
    dir_known[3] = 1'b1; dir_val[3] = 52'd1 << 24;
    // Point against segment, segment against point, parallel, end clamps.
    dir_crd[4][6] = -24'sd8192; dir_crd[4][9] = 24'sd8192; dir_crd[4][1] = 24'sd4096;
    dir_crd[4][4] = 24'sd4096;
    dir_crd[5][0] = -24'sd8192; dir_crd[5][3] = 24'sd8192; dir_crd[5][7] = 24'sd100;
    dir_crd[5][10] = 24'sd100;
    dir_crd[6][3] = 24'sd9000; dir_crd[6][7] = 24'sd50; dir_crd[6][6] = 24'sd3000;
    dir_crd[6][10] = 24'sd50; dir_crd[6][9] = 24'sd15000;
    dir_crd[7][3] = 24'sd4096; dir_crd[7][6] = 24'sd20000; dir_crd[7][9] = 24'sd30000;
    dir_crd[7][10] = 24'sd500;
    dir_crd[8][3] = 24'sd4096; dir_crd[8][6] = -24'sd20000; dir_crd[8][9] = -24'sd30000;
    dir_crd[8][11] = 24'sd700;
    for (int i = 0; i < 12; i++) begin
      dir_crd[9][i] = (i % 2) ? mx : mn;
      dir_crd[10][i] = -24'sd1;
      dir_crd[11][i] = (i < 6) ? 24'sd1 : 24'sd0;
    end
    dir_crd[12][3] = 24'sd10; dir_crd[12][9] = 24'sd3; dir_crd[12][7] = 24'sd2;
    dir_crd[13][5] = mx; dir_crd[13][11] = mn; dir_crd[13][6] = 24'sd1234;

    query.valid = 1'b0;
    cfg.valid = 1'b0;
    cfg.near_zero_limit = '0;
    query.first_start_x = '0; query.first_start_y = '0; query.first_start_z = '0;
    query.first_end_x = '0; query.first_end_y = '0; query.first_end_z = '0;
    query.second_start_x = '0; query.second_start_y = '0; query.second_start_z = '0;
    query.second_end_x = '0; query.second_end_y = '0; query.second_end_z = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table at the reset threshold.
    for (int k = 0; k < NUM_DIRECTED; k++) begin
      for (int i = 0; i < 12; i++) r.crd[i] = dir_crd[k][i];
      send_request(r, dir_known[k], dir_val[k]);
    end
    wait_drained();

    // Random requests across several threshold settings.
    for (int ph = 0; ph < 4; ph++) begin
      write_limit(limits[ph]);
      for (int n = 0; n < NUM_RANDOM / 4; n++) send_request(pick_request(), 1'b0, '0);
      wait_drained();
    end
    stim_done = 1'b1;
  end

  // End of run.
  initial begin
    wait (stim_done);
    if (errors == 0 && pending_dist.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
